// ----- hdl/playfair_digraph_cipher_assert.svh -----
// Assertion macros shared by the Playfair cipher RTL.
`ifndef PLAYFAIR_DIGRAPH_CIPHER_ASSERT_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_ASSERT_SVH

// Condition must hold at every clock edge out of reset.
`define PFC_ASSERT(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Same-cycle implication.
`define PFC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PFC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/pfc_pkg.sv -----
// Types, constants and helper functions of the Playfair cipher.
package pfc_pkg;

    localparam int SIDE = 5;

    typedef logic [4:0] t_letter;

    localparam t_letter LETTER_X = 5'd23;
    localparam t_letter LETTER_J = 5'd9;
    localparam t_letter LETTER_I = 5'd8;

    // Config register indexes
    typedef enum logic [1:0] {
        CFG_ROWS_0_1 = 2'd0,
        CFG_ROWS_2_3 = 2'd1,
        CFG_ROW_4    = 2'd2
    } t_cfg_idx;

    // [row][col][bit]; flat bit 25*row + 5*col + bit matches the register layout
    typedef logic [SIDE-1:0][SIDE-1:0][4:0] t_square;

    typedef struct packed {
        logic [2:0] row;
        logic [2:0] col;
    } t_pos;

    // One digraph to encipher or decipher
    typedef struct packed {
        t_letter a;
        t_letter b;
        logic    dec;
        logic    last;
    } t_job;

    typedef struct packed {
        t_letter first;
        t_letter second;
        logic    last;
    } t_result;

    // Lowest cell holding the letter; cell 0 if absent.
    function automatic t_pos find_pos(input t_square sq, input t_letter l);
        t_pos p;
        p = '0;
        for (int r = SIDE - 1; r >= 0; r--) begin
            for (int c = SIDE - 1; c >= 0; c--) begin
                if (sq[r][c] == l) begin
                    p.row = 3'(r);
                    p.col = 3'(c);
                end
            end
        end
        return p;
    endfunction

    // One step along a row or column with wrap; backwards when deciphering.
    function automatic logic [2:0] wrap_step(input logic [2:0] v, input logic dec);
        logic [2:0] r;
        if (dec) begin
            r = (v == 3'd0) ? 3'(SIDE - 1) : v - 3'd1;
        end else begin
            r = (v == 3'(SIDE - 1)) ? 3'd0 : v + 3'd1;
        end
        return r;
    endfunction

endpackage

// ----- hdl/playfair_digraph_cipher.sv -----
// Top level of the Playfair digraph cipher.
// Playfair digraph cipher, one letter per transaction. The 5x5 key square is
// loaded through the config port (index 0: cells 0..9, index 1: cells 10..19,
// index 2: cells 20..24, 5 bits per cell, cell k of a register at bit 5k) and
// should only be written while no transaction is in progress. Encrypt mode
// (mode=0) folds j into i, splits doubled letters with x and pads a lone final
// letter with x; decrypt mode pairs letters as they come and drops a lone final
// letter. Each digraph gives one result transaction; last_pair flags the final
// result caused by an input letter (a letter can cause zero, one or two).
// Throughput: one letter accepted per cycle while full is low and one result
// delivered per cycle while pop keeps the result queue drained; the result side
// is the limit when letters cause two results. A result that a letter completes
// passes through the job queue, the square lookup stage and the result queue,
// each registered, before it is visible on the output. When one letter makes
// two digraphs both jobs enter the job queue together and the second result
// follows the first, and a result queue that is not drained holds jobs back in
// the job queue. full goes high when the job queue has fewer than two free
// slots; no reset sweep is needed, the block is ready right out of reset.
module playfair_digraph_cipher #(
    parameter int JOB_DEPTH = 4,
    parameter int OUT_DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // letter side
    input  logic                push,
    output logic                full,
    input  logic                i_mode,
    input  logic [4:0]          i_letter,
    input  logic                i_end_of_text,
    // result side
    output logic                empty,
    input  logic                pop,
    output logic [4:0]          o_first_letter,
    output logic [4:0]          o_second_letter,
    output logic                o_last_pair,
    // config write port
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [49:0]         i_cfg_data
);
    import pfc_pkg::*;

    t_square r_square;
    logic    accept;
    logic    job0_valid;
    logic    job1_valid;
    t_job    job0;
    t_job    job1;
    logic    room;
    logic    q_valid;
    t_job    q_job;
    logic    q_pop;
    t_result result;

    // key square registers; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_square <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ROWS_0_1: r_square[1:0] <= i_cfg_data;
                CFG_ROWS_2_3: r_square[3:2] <= i_cfg_data;
                CFG_ROW_4:    r_square[4]   <= i_cfg_data[24:0];
                default: ;
            endcase
        end
    end

    // need two free job slots since one letter can make two digraphs
    assign full   = !room;
    assign accept = push && room;

    pfc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_mode        (i_mode),
        .i_letter      (i_letter),
        .i_end_of_text (i_end_of_text),
        .o_job0_valid  (job0_valid),
        .o_job0        (job0),
        .o_job1_valid  (job1_valid),
        .o_job1        (job1)
    );

    pfc_queue #(
        .DEPTH (JOB_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push0 (job0_valid),
        .i_job0  (job0),
        .i_push1 (job1_valid),
        .i_job1  (job1),
        .o_room  (room),
        .o_valid (q_valid),
        .o_job   (q_job),
        .i_pop   (q_pop)
    );

    pfc_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_square    (r_square),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .o_job_pop   (q_pop),
        .o_empty     (empty),
        .o_result    (result),
        .i_pop       (pop)
    );

    assign o_first_letter  = result.first;
    assign o_second_letter = result.second;
    assign o_last_pair     = result.last;

endmodule

// ----- hdl/pfc_front.sv -----
// Front end: holds the waiting letter and turns each letter into zero to two digraph jobs.
module pfc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic           i_mode,
    input  pfc_pkg::t_letter i_letter,
    input  logic           i_end_of_text,
    output logic           o_job0_valid,
    output pfc_pkg::t_job  o_job0,
    output logic           o_job1_valid,
    output pfc_pkg::t_job  o_job1
);
    import pfc_pkg::*;

    logic    r_pv;
    t_letter r_pl;
    logic    n_pv;
    t_letter n_pl;
    t_letter let_e;
    logic    mid_pv;
    t_letter mid_pl;

    assign let_e = (i_letter == LETTER_J) ? LETTER_I : i_letter;

    always_comb begin
        n_pv         = r_pv;
        n_pl         = r_pl;
        mid_pv       = r_pv;
        mid_pl       = r_pl;
        o_job0_valid = 1'b0;
        o_job1_valid = 1'b0;
        o_job0       = '0;
        o_job1       = '0;
        if (i_accept) begin
            if (i_mode) begin
                if (r_pv) begin
                    o_job0_valid = 1'b1;
                    o_job0       = '{a: r_pl, b: i_letter, dec: 1'b1, last: 1'b1};
                    n_pv         = 1'b0;
                    n_pl         = '0;
                end else if (!i_end_of_text) begin
                    n_pv = 1'b1;
                    n_pl = i_letter;
                end
            end else begin
                if (r_pv) begin
                    o_job0_valid = 1'b1;
                    if (r_pl != let_e) begin
                        o_job0 = '{a: r_pl, b: let_e, dec: 1'b0, last: 1'b1};
                        mid_pv = 1'b0;
                        mid_pl = '0;
                    end else begin
                        // doubled letter: split with x, second one waits
                        o_job0 = '{a: r_pl, b: LETTER_X, dec: 1'b0, last: 1'b1};
                        mid_pv = 1'b1;
                        mid_pl = let_e;
                    end
                end else begin
                    mid_pv = 1'b1;
                    mid_pl = let_e;
                end
                n_pv = mid_pv;
                n_pl = mid_pl;
                if (i_end_of_text && mid_pv) begin
                    n_pv = 1'b0;
                    n_pl = '0;
                    if (o_job0_valid) begin
                        o_job0.last  = 1'b0;
                        o_job1_valid = 1'b1;
                        o_job1 = '{a: mid_pl, b: LETTER_X, dec: 1'b0, last: 1'b1};
                    end else begin
                        o_job0_valid = 1'b1;
                        o_job0 = '{a: mid_pl, b: LETTER_X, dec: 1'b0, last: 1'b1};
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            r_pl <= '0;
        end else begin
            r_pv <= n_pv;
            r_pl <= n_pl;
        end
    end

`include "playfair_digraph_cipher_assert.svh"

    `PFC_ASSERT_IMPL(a_two_jobs_enc_eot, o_job1_valid, o_job0_valid && !i_mode && i_end_of_text, "second job without first or outside encrypt end")
    `PFC_ASSERT_NEXT(a_eot_clears, i_accept && i_end_of_text, !r_pv, "letter left waiting after end of text")

endmodule

// ----- hdl/pfc_queue.sv -----
// Job queue between front and back; takes up to two jobs a cycle, gives one when the back end pops.
module pfc_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push0,
    input  pfc_pkg::t_job i_job0,
    input  logic          i_push1,
    input  pfc_pkg::t_job i_job1,
    output logic          o_room,
    output logic          o_valid,
    output pfc_pkg::t_job o_job,
    input  logic          i_pop
);
    import pfc_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_job           r_mem [DEPTH];
    logic [PW-1:0]  r_wp;
    logic [PW-1:0]  r_rp;
    logic [CW-1:0]  r_cnt;
    logic [PW-1:0]  wp1;
    logic [PW-1:0]  wp2;
    logic [PW-1:0]  rp1;

    function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign wp1     = nxt(r_wp);
    assign wp2     = nxt(wp1);
    assign rp1     = nxt(r_rp);
    assign o_room  = r_cnt <= CW'(DEPTH - 2);
    assign o_valid = r_cnt != '0;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push0) begin
            r_mem[r_wp] <= i_job0;
        end
        if (i_push1) begin
            r_mem[wp1] <= i_job1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push1) begin
                r_wp <= wp2;
            end else if (i_push0) begin
                r_wp <= wp1;
            end
            if (i_pop) begin
                r_rp <= rp1;
            end
            r_cnt <= r_cnt + CW'(i_push0) + CW'(i_push1) - CW'(i_pop);
        end
    end

`include "playfair_digraph_cipher_assert.svh"

    `PFC_ASSERT(a_cnt_bound, r_cnt <= CW'(DEPTH), "job queue overflow")
    `PFC_ASSERT_IMPL(a_pop_nonempty, i_pop, r_cnt != '0, "job queue popped while empty")

endmodule

// ----- hdl/pfc_back.sv -----
// Back end: square lookup stage, combinational digraph rules and result queue.
module pfc_back #(
    parameter int OUT_DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pfc_pkg::t_square  i_square,
    input  logic              i_job_valid,
    input  pfc_pkg::t_job     i_job,
    output logic              o_job_pop,
    output logic              o_empty,
    output pfc_pkg::t_result  o_result,
    input  logic              i_pop
);
    import pfc_pkg::*;

    localparam int PW = $clog2(OUT_DEPTH);
    localparam int CW = $clog2(OUT_DEPTH + 1);

    // lookup stage
    logic  r_a_valid;
    t_pos  r_pa;
    t_pos  r_pb;
    logic  r_a_dec;
    logic  r_a_last;

    // result queue
    t_result        r_mem [OUT_DEPTH];
    logic [PW-1:0]  r_wp;
    logic [PW-1:0]  r_rp;
    logic [CW-1:0]  r_cnt;

    logic [CW:0]    in_flight;
    logic           issue;
    logic           deq;
    t_pos           na;
    t_pos           nb;
    t_result        res;

    function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
        return (p == PW'(OUT_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // issue only when the result queue can take every job in flight
    assign in_flight = {1'b0, r_cnt} + (CW + 1)'(r_a_valid);
    assign issue     = i_job_valid && (in_flight < (CW + 1)'(OUT_DEPTH));
    assign o_job_pop = issue;

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_pa     <= find_pos(i_square, i_job.a);
            r_pb     <= find_pos(i_square, i_job.b);
            r_a_dec  <= i_job.dec;
            r_a_last <= i_job.last;
        end
    end

    always_comb begin
        priority if (r_pa.row == r_pb.row) begin
            na = '{row: r_pa.row, col: wrap_step(r_pa.col, r_a_dec)};
            nb = '{row: r_pb.row, col: wrap_step(r_pb.col, r_a_dec)};
        end else if (r_pa.col == r_pb.col) begin
            na = '{row: wrap_step(r_pa.row, r_a_dec), col: r_pa.col};
            nb = '{row: wrap_step(r_pb.row, r_a_dec), col: r_pb.col};
        end else begin
            na = '{row: r_pa.row, col: r_pb.col};
            nb = '{row: r_pb.row, col: r_pa.col};
        end
        res.first  = i_square[na.row][na.col];
        res.second = i_square[nb.row][nb.col];
        res.last   = r_a_last;
    end

    assign deq      = i_pop && (r_cnt != '0);
    assign o_empty  = r_cnt == '0;
    assign o_result = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (r_a_valid) begin
            r_mem[r_wp] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_wp      <= '0;
            r_rp      <= '0;
            r_cnt     <= '0;
        end else begin
            r_a_valid <= issue;
            if (r_a_valid) begin
                r_wp <= nxt(r_wp);
            end
            if (deq) begin
                r_rp <= nxt(r_rp);
            end
            r_cnt <= r_cnt + CW'(r_a_valid) - CW'(deq);
        end
    end

`include "playfair_digraph_cipher_assert.svh"

    `PFC_ASSERT(a_credit, in_flight <= (CW + 1)'(OUT_DEPTH), "result queue overcommitted")
    `PFC_ASSERT_NEXT(a_issue_lands, issue, r_a_valid, "issued job lost before lookup stage")

endmodule
